// ----- hdl/hmac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hmac_pkg;

    // Field widths of the stream payloads
    localparam int SCORE_W   = 16;
    localparam int PEAK_W    = 10;
    localparam int ORIGIN_W  = 16;
    localparam int BLANK_W   = 16;
    localparam int SRC_W     = 15;
    localparam int COPY_W    = 13;

    // Register widths
    localparam int MAPW_W    = 11;
    localparam int DIM_W     = 13;
    localparam int COEF_W    = 32;

    // Q16.16 fraction bits, and the shift that gives half a crop in Q16.16
    localparam int FRAC_W    = 16;
    localparam int HALF_SH   = 15;

    // Configuration channel
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_HEIGHT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_WIDTH  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_SCALE   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COL_SCALE   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COL_OFFSET  = 4'd7;

    localparam int M_TDATA_W = 136;

    typedef logic signed [SCORE_W-1:0]  score_t;
    typedef logic signed [ORIGIN_W-1:0] origin_t;
    typedef logic [DIM_W-1:0]           dim_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

endpackage

`default_nettype wire

// ----- hdl/hmac_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hmac_tracker #(
    parameter int MAX_MAP_DIM = 1024,
    parameter int IDX_W       = 10
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       take,
    input  wire hmac_pkg::score_t           score,
    input  wire logic                       map_end,
    input  wire logic [hmac_pkg::MAPW_W-1:0] map_width,
    output logic [IDX_W-1:0]                peak_row,
    output logic [IDX_W-1:0]                peak_col,
    output hmac_pkg::score_t                peak_score
);
    import hmac_pkg::*;

    localparam int CW = 14;

    score_t           best_score_reg;
    logic [IDX_W-1:0] best_row_reg;
    logic [IDX_W-1:0] best_col_reg;
    logic [IDX_W-1:0] scan_row_reg;
    logic [IDX_W-1:0] scan_col_reg;
    logic             first_seen_reg;

    score_t           best_score_next;
    logic [IDX_W-1:0] best_row_next;
    logic [IDX_W-1:0] best_col_next;
    logic [CW-1:0]    col_inc;
    logic             col_wrap;
    logic             row_wrap;

    // Keep the first maximum: replace only on a strictly greater score
    always_comb begin
        if (!first_seen_reg || (score > best_score_reg)) begin
            best_score_next = score;
            best_row_next   = scan_row_reg;
            best_col_next   = scan_col_reg;
        end else begin
            best_score_next = best_score_reg;
            best_row_next   = best_row_reg;
            best_col_next   = best_col_reg;
        end
    end

    // Raster position: wrap at the row length or at the largest map dimension
    assign col_inc  = CW'(scan_col_reg) + CW'(1);
    assign col_wrap = (col_inc >= CW'(map_width)) || (col_inc >= CW'(MAX_MAP_DIM));
    assign row_wrap = (CW'(scan_row_reg) + CW'(1)) >= CW'(MAX_MAP_DIM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_score_reg <= '0;
            best_row_reg   <= '0;
            best_col_reg   <= '0;
            scan_row_reg   <= '0;
            scan_col_reg   <= '0;
            first_seen_reg <= 1'b0;
        end else if (take) begin
            best_score_reg <= best_score_next;
            best_row_reg   <= best_row_next;
            best_col_reg   <= best_col_next;
            if (map_end) begin
                scan_row_reg   <= '0;
                scan_col_reg   <= '0;
                first_seen_reg <= 1'b0;
            end else begin
                first_seen_reg <= 1'b1;
                if (col_wrap) begin
                    scan_col_reg <= '0;
                    scan_row_reg <= row_wrap ? '0 : scan_row_reg + IDX_W'(1);
                end else begin
                    scan_col_reg <= col_inc[IDX_W-1:0];
                end
            end
        end
    end

    // Capture the peak of a finished channel
    always_ff @(posedge aclk) begin
        if (take && map_end) begin
            peak_row   <= best_row_next;
            peak_col   <= best_col_next;
            peak_score <= best_score_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hmac_axis.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hmac_axis #(
    parameter int IDX_W = 10
) (
    input  wire logic                aclk,
    input  wire logic                mul_en,
    input  wire logic                sum_en,
    input  wire logic [IDX_W-1:0]    idx,
    input  wire hmac_pkg::coef_t     scale,
    input  wire hmac_pkg::coef_t     offset,
    input  wire hmac_pkg::dim_t      crop,
    output logic [IDX_W-1:0]         idx_out,
    output hmac_pkg::origin_t        origin
);
    import hmac_pkg::*;

    localparam int PW = COEF_W + IDX_W + 1;
    localparam int SW = PW + 2;

    logic signed [PW-1:0] scale_x;
    logic signed [PW-1:0] idx_x;
    logic signed [PW-1:0] prod_reg;
    logic [IDX_W-1:0]     idx_mul_reg;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] fl;
    origin_t              origin_next;

    // Multiply stage: scale times heatmap index
    assign scale_x = PW'(scale);
    assign idx_x   = PW'($signed({1'b0, idx}));

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg    <= scale_x * idx_x;
            idx_mul_reg <= idx;
        end
    end

    // Add offset, remove half the crop, floor by arithmetic shift, saturate
    assign sum = SW'(prod_reg) + SW'(offset)
               - SW'($signed({1'b0, crop, {HALF_SH{1'b0}}}));
    assign fl  = sum >>> FRAC_W;

    always_comb begin
        priority if (fl > SW'(32767)) begin
            origin_next = 16'sh7FFF;
        end else if (fl < -SW'(32768)) begin
            origin_next = 16'sh8000;
        end else begin
            origin_next = fl[ORIGIN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_en) begin
            origin  <= origin_next;
            idx_out <= idx_mul_reg;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hmac_clip.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hmac_clip #(
    parameter int IDX_W = 10
) (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire hmac_pkg::origin_t             origin_row,
    input  wire hmac_pkg::origin_t             origin_col,
    input  wire hmac_pkg::dim_t                image_width,
    input  wire hmac_pkg::dim_t                crop_width,
    input  wire logic [IDX_W-1:0]              row_in,
    input  wire logic [IDX_W-1:0]              col_in,
    input  wire hmac_pkg::score_t              score_in,
    output logic [hmac_pkg::M_TDATA_W-1:0]     result
);
    import hmac_pkg::*;

    logic signed [ORIGIN_W:0] neg_row;
    logic signed [ORIGIN_W:0] neg_col;
    logic [BLANK_W-1:0]       top_pad;
    logic [BLANK_W-1:0]       left_pad;
    logic [SRC_W-1:0]         source_col;
    logic signed [17:0]       end_col;
    logic signed [17:0]       img_col;
    logic signed [17:0]       end_min;
    logic signed [18:0]       copy;
    logic                     skip;
    logic [COPY_W-1:0]        copy_width;

    // Blank widths and the clipped start column
    assign neg_row    = -(ORIGIN_W+1)'(origin_row);
    assign neg_col    = -(ORIGIN_W+1)'(origin_col);
    assign top_pad    = origin_row[ORIGIN_W-1] ? neg_row[BLANK_W-1:0] : '0;
    assign left_pad   = origin_col[ORIGIN_W-1] ? neg_col[BLANK_W-1:0] : '0;
    assign source_col = origin_col[ORIGIN_W-1] ? '0 : origin_col[SRC_W-1:0];

    // Clip the right edge and measure the copy
    assign end_col = 18'(origin_col) + 18'($signed({1'b0, crop_width}));
    assign img_col = 18'($signed({1'b0, image_width}));
    assign end_min = (img_col < end_col) ? img_col : end_col;
    assign copy    = 19'(end_min) - 19'($signed({1'b0, source_col}));
    assign skip    = copy[18] || (copy == '0);
    assign copy_width = skip ? '0 : copy[COPY_W-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            result <= {7'd0, skip, copy_width, source_col, left_pad, top_pad,
                       origin_col, origin_row, score_in,
                       PEAK_W'(col_in), PEAK_W'(row_in)};
        end
    end

endmodule

`default_nettype wire

// ----- hdl/heatmap_argmax_crop_window_unit.sv -----
// Heatmap peak to crop window.
// s_ channel: one Q8.8 score per transfer in raster order, s_tlast on the
// last score of a channel. The first maximum is kept (strictly greater wins).
// m_ channel: one result per channel, sent after its s_tlast transfer.
// cfg channel: register writes (index, data); cfg_ready is always high.
// The user must write registers only while no channel is in flight; the
// block does not enforce this. Throughput: one score per cycle while s_tready
// is high. A channel's result reaches m_tvalid through four registered stages:
// peak capture at the edge that takes its last score, the Q16.16 multiply,
// offset/floor/saturate, and the clip that loads the output register.
// When the receiver stalls, stages fill one by one; s_tready falls only when
// the capture stage holds a result that cannot move on, so up to three
// results can wait while scores still stream in, and a fourth stops the input.
// Reset (aresetn low, synchronous) clears the scan position, the kept peak,
// all stage valid flags and loads the registers with their defaults: widths
// of one, unit scales and zero offsets.
`timescale 1ns / 1ps
`default_nettype none

module heatmap_argmax_crop_window_unit #(
    parameter int MAX_MAP_DIM = 1024
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [15:0]                         s_tdata,  // score
    input  wire logic                                s_tlast,  // map_end
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // peak_row, peak_col, peak_score, origin_row, origin_col, top_pad,
    // left_pad, source_col, copy_width, skip_patch
    output logic [hmac_pkg::M_TDATA_W-1:0]           m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [hmac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [31:0]                         cfg_data
);
    import hmac_pkg::*;

    localparam int IDX_W = $clog2(MAX_MAP_DIM);

    logic [MAPW_W-1:0] map_width_reg;
    dim_t              image_width_reg;
    dim_t              crop_height_reg;
    dim_t              crop_width_reg;
    coef_t             row_scale_reg;
    coef_t             row_offset_reg;
    coef_t             col_scale_reg;
    coef_t             col_offset_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic take;

    logic [IDX_W-1:0] p1_row, p1_col;
    score_t           p1_score;
    score_t           p2_score_reg, p3_score_reg;
    logic [IDX_W-1:0] p3_row, p3_col;
    origin_t          origin_row, origin_col;

    // Register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg   <= MAPW_W'(1);
            image_width_reg <= DIM_W'(1);
            crop_height_reg <= DIM_W'(1);
            crop_width_reg  <= DIM_W'(1);
            row_scale_reg   <= 32'sd65536;
            row_offset_reg  <= '0;
            col_scale_reg   <= 32'sd65536;
            col_offset_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAP_WIDTH:   map_width_reg   <= cfg_data[MAPW_W-1:0];
                REG_IMAGE_WIDTH: image_width_reg <= cfg_data[DIM_W-1:0];
                REG_CROP_HEIGHT: crop_height_reg <= cfg_data[DIM_W-1:0];
                REG_CROP_WIDTH:  crop_width_reg  <= cfg_data[DIM_W-1:0];
                REG_ROW_SCALE:   row_scale_reg   <= cfg_data;
                REG_ROW_OFFSET:  row_offset_reg  <= cfg_data;
                REG_COL_SCALE:   col_scale_reg   <= cfg_data;
                REG_COL_OFFSET:  col_offset_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Elastic stage control: a stage moves when it is empty or the next moves
    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign take     = s_tvalid && rdy1;
    assign m_tvalid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= take && s_tlast;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Running maximum over the channel
    hmac_tracker #(
        .MAX_MAP_DIM (MAX_MAP_DIM),
        .IDX_W       (IDX_W)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .score      (s_tdata),
        .map_end    (s_tlast),
        .map_width  (map_width_reg),
        .peak_row   (p1_row),
        .peak_col   (p1_col),
        .peak_score (p1_score)
    );

    // Map each axis to an image origin
    hmac_axis #(
        .IDX_W (IDX_W)
    ) u_row_axis (
        .aclk    (aclk),
        .mul_en  (rdy2 && v1_reg),
        .sum_en  (rdy3 && v2_reg),
        .idx     (p1_row),
        .scale   (row_scale_reg),
        .offset  (row_offset_reg),
        .crop    (crop_height_reg),
        .idx_out (p3_row),
        .origin  (origin_row)
    );

    hmac_axis #(
        .IDX_W (IDX_W)
    ) u_col_axis (
        .aclk    (aclk),
        .mul_en  (rdy2 && v1_reg),
        .sum_en  (rdy3 && v2_reg),
        .idx     (p1_col),
        .scale   (col_scale_reg),
        .offset  (col_offset_reg),
        .crop    (crop_width_reg),
        .idx_out (p3_col),
        .origin  (origin_col)
    );

    // Carry the peak score alongside the axis stages
    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) p2_score_reg <= p1_score;
        if (rdy3 && v2_reg) p3_score_reg <= p2_score_reg;
    end

    // Clip against the image edges into the output register
    hmac_clip #(
        .IDX_W (IDX_W)
    ) u_clip (
        .aclk        (aclk),
        .load        (rdy4 && v3_reg),
        .origin_row  (origin_row),
        .origin_col  (origin_col),
        .image_width (image_width_reg),
        .crop_width  (crop_width_reg),
        .row_in      (p3_row),
        .col_in      (p3_col),
        .score_in    (p3_score_reg),
        .result      (m_tdata)
    );

`ifndef SYNTHESIS
    a_mid_score_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tlast) |=> !v1_reg)
        else $error("non-final score started a result");

    a_stalled_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !m_tready) |=> (v4_reg && $stable(m_tdata)))
        else $error("stalled result lost or changed");

    a_skip_zero_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && m_tdata[128]) |-> (m_tdata[127:115] == '0))
        else $error("skipped patch with nonzero copy width");

    a_top_pad_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> ((m_tdata[83:68] == '0) == !m_tdata[51]))
        else $error("top pad disagrees with origin row sign");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_heatmap_argmax_crop_window_unit.sv -----
`timescale 1ns / 1ps

module tb_heatmap_argmax_crop_window_unit;
    import hmac_pkg::*;

    localparam int MAP_DIM       = 1024;
    localparam int NUM_REGS      = 8;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int LONG_LEN      = 1026;
    localparam int LONG_PEAK     = 1025;
    localparam int SCALE_SPAN    = 8 << FRAC_W;
    localparam int OFFSET_SPAN   = 1 << 26;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;

    localparam longint ORIGIN_MAX = 32767;
    localparam longint ORIGIN_MIN = -32768;

    localparam score_t SCORE_TOP = 16'sh7FFF;
    localparam score_t SCORE_BOT = 16'sh8000;

    // Settings sequence after the directed rows
    localparam int PH_HIGH     = 0;
    localparam int PH_LOW      = 1;
    localparam int PH_WIDE     = 2;
    localparam int PH_HOLD     = 3;
    localparam int PH_ROW_WRAP = 9;
    localparam int PH_COL_WRAP = 10;
    localparam int NUM_PHASES  = 11;

    localparam int SIDE_SRC  = 0;
    localparam int SIDE_SINK = 1;

    typedef struct packed {
        logic [PEAK_W-1:0]  peak_row;
        logic [PEAK_W-1:0]  peak_col;
        score_t             peak_score;
        origin_t            origin_row;
        origin_t            origin_col;
        logic [BLANK_W-1:0] top_pad;
        logic [BLANK_W-1:0] left_pad;
        logic [SRC_W-1:0]   source_col;
        logic [COPY_W-1:0]  copy_width;
        logic               skip_patch;
    } crop_t;

    typedef struct packed {
        score_t score;
        logic   last;
        logic   typed;
        crop_t  want;
    } dir_row_t;

    localparam crop_t NO_WANT = '0;

    // Reset settings: 1x1 crop, unit scale, image one column wide
    localparam dir_row_t DIRECTED [16] = '{
        // single-score channels: peak at the origin, window one pixel off the top and left, patch skipped
        '{16'sd0,    1'b1, 1'b1,
          '{10'd0, 10'd0, 16'sd0, -16'sd1, -16'sd1, 16'd1, 16'd1, 15'd0, 13'd0, 1'b1}},
        '{SCORE_TOP, 1'b1, 1'b1,
          '{10'd0, 10'd0, SCORE_TOP, -16'sd1, -16'sd1, 16'd1, 16'd1, 15'd0, 13'd0, 1'b1}},
        '{SCORE_BOT, 1'b1, 1'b1,
          '{10'd0, 10'd0, SCORE_BOT, -16'sd1, -16'sd1, 16'd1, 16'd1, 15'd0, 13'd0, 1'b1}},
        // tie on the maximum: the first one is kept
        '{16'sd5,    1'b0, 1'b0, NO_WANT},
        '{16'sd7,    1'b0, 1'b0, NO_WANT},
        '{16'sd7,    1'b0, 1'b0, NO_WANT},
        '{-16'sd3,   1'b1, 1'b0, NO_WANT},
        // all scores at the minimum
        '{SCORE_BOT, 1'b0, 1'b0, NO_WANT},
        '{SCORE_BOT, 1'b0, 1'b0, NO_WANT},
        '{SCORE_BOT, 1'b1, 1'b0, NO_WANT},
        // alternating bit patterns, peak in the third row
        '{16'sh5555, 1'b0, 1'b0, NO_WANT},
        '{16'shAAAA, 1'b0, 1'b0, NO_WANT},
        '{SCORE_TOP, 1'b0, 1'b0, NO_WANT},
        '{16'sd1,    1'b1, 1'b0, NO_WANT},
        // negative scores only
        '{-16'sd1,   1'b0, 1'b0, NO_WANT},
        '{-16'sd2,   1'b1, 1'b0, NO_WANT}
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [15:0]            s_tdata;   // score
    logic                   s_tlast;   // map_end
    logic                   m_tvalid;
    logic                   m_tready;
    // peak_row, peak_col, peak_score, origin_row, origin_col, top_pad,
    // left_pad, source_col, copy_width, skip_patch
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [31:0]            cfg_data;

    // Predictor copy of the registers, reset values
    logic [MAPW_W-1:0] map_w    = 1;
    dim_t              img_w    = 1;
    dim_t              crop_h   = 1;
    dim_t              crop_w   = 1;
    longint            row_gain = 65536;
    longint            row_ofs  = 0;
    longint            col_gain = 65536;
    longint            col_ofs  = 0;

    // Predictor copy of the peak tracker
    score_t            best_score = '0;
    logic [PEAK_W-1:0] best_row   = '0;
    logic [PEAK_W-1:0] best_col   = '0;
    logic [PEAK_W-1:0] scan_row   = '0;
    logic [PEAK_W-1:0] scan_col   = '0;
    logic              seen       = 1'b0;

    crop_t crop_q [$];
    int    mismatches  = 0;
    int    idle_cycles = 0;
    int    calm_left [2] = '{0, 0};
    bit    hold_req    = 1'b0;

    heatmap_argmax_crop_window_unit #(
        .MAX_MAP_DIM (MAP_DIM)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Random wait before the next transfer, with calm stretches of no wait
    function automatic int draw_wait(int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) calm_left[side] = $urandom_range(8, 40);
        return $urandom_range(0, 4);
    endfunction

    function automatic score_t pick_score();
        case ($urandom_range(0, 7))
            0: return SCORE_TOP;
            1: return SCORE_BOT;
            2: return score_t'($urandom_range(0, 3));
            default: return score_t'($urandom);
        endcase
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (idx)
            REG_MAP_WIDTH:   map_w    = val[MAPW_W-1:0];
            REG_IMAGE_WIDTH: img_w    = val[DIM_W-1:0];
            REG_CROP_HEIGHT: crop_h   = val[DIM_W-1:0];
            REG_CROP_WIDTH:  crop_w   = val[DIM_W-1:0];
            REG_ROW_SCALE:   row_gain = longint'(coef_t'(val));
            REG_ROW_OFFSET:  row_ofs  = longint'(coef_t'(val));
            REG_COL_SCALE:   col_gain = longint'(coef_t'(val));
            REG_COL_OFFSET:  col_ofs  = longint'(coef_t'(val));
            default: ;
        endcase
    endfunction

    // Map the kept peak to the crop window and clip it against the image
    function automatic crop_t crop_window();
        longint vr, vc, orow, ocol, top_rows, left_cols, src, endc, cp;
        crop_t  r;
        vr = row_gain * longint'(best_row) + row_ofs - (longint'(crop_h) <<< HALF_SH);
        vc = col_gain * longint'(best_col) + col_ofs - (longint'(crop_w) <<< HALF_SH);
        // arithmetic shift floors toward minus infinity
        orow = vr >>> FRAC_W;
        ocol = vc >>> FRAC_W;
        if (orow > ORIGIN_MAX) orow = ORIGIN_MAX;
        if (orow < ORIGIN_MIN) orow = ORIGIN_MIN;
        if (ocol > ORIGIN_MAX) ocol = ORIGIN_MAX;
        if (ocol < ORIGIN_MIN) ocol = ORIGIN_MIN;
        top_rows  = (orow < 0) ? -orow : 0;
        left_cols = (ocol < 0) ? -ocol : 0;
        src  = ocol + left_cols;
        endc = ocol + longint'(crop_w);
        if (longint'(img_w) < endc) endc = longint'(img_w);
        cp = endc - src;
        r.peak_row   = best_row;
        r.peak_col   = best_col;
        r.peak_score = best_score;
        r.origin_row = orow[ORIGIN_W-1:0];
        r.origin_col = ocol[ORIGIN_W-1:0];
        r.top_pad    = top_rows[BLANK_W-1:0];
        r.left_pad   = left_cols[BLANK_W-1:0];
        r.source_col = src[SRC_W-1:0];
        r.skip_patch = (cp <= 0);
        r.copy_width = r.skip_patch ? '0 : cp[COPY_W-1:0];
        return r;
    endfunction

    // Track one score; on the channel's last score produce its window
    function automatic bit take_score(score_t sc, logic last, output crop_t res);
        int next_col;
        res = '0;
        if (!seen || sc > best_score) begin
            best_score = sc;
            best_row   = scan_row;
            best_col   = scan_col;
        end
        seen = 1'b1;
        if (!last) begin
            next_col = int'(scan_col) + 1;
            if (next_col >= int'(map_w) || next_col >= MAP_DIM) begin
                scan_col = '0;
                scan_row = scan_row + 1'b1;
            end else begin
                scan_col = scan_col + 1'b1;
            end
            return 1'b0;
        end
        res      = crop_window();
        scan_row = '0;
        scan_col = '0;
        seen     = 1'b0;
        return 1'b1;
    endfunction

    // Called and returns at a falling edge; leaves s_tvalid high
    task automatic send_score(score_t sc, logic last, logic use_typed = 1'b0,
                              crop_t typed_want = '0);
        int    gap;
        crop_t res;
        gap = draw_wait(SIDE_SRC);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sc;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (take_score(sc, last, res)) crop_q.push_back(use_typed ? typed_want : res);
        @(negedge aclk);
    endtask

    // peak_at >= 0 places the single top score at that position
    task automatic send_channel(int len, int peak_at);
        score_t sc;
        for (int i = 0; i < len; i++) begin
            sc = pick_score();
            if (peak_at >= 0) begin
                if (i == peak_at) sc = SCORE_TOP;
                else if (sc == SCORE_TOP) sc = score_t'(sc - 1);
            end
            send_score(sc, i == len - 1);
        end
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic load_settings(int ph);
        logic [31:0] v [NUM_REGS];
        v[REG_MAP_WIDTH]   = $urandom_range(1, 24);
        v[REG_IMAGE_WIDTH] = $urandom_range(1, 4096);
        v[REG_CROP_HEIGHT] = ($urandom_range(0, 7) == 0) ? 4096 : $urandom_range(1, 300);
        v[REG_CROP_WIDTH]  = ($urandom_range(0, 7) == 0) ? 4096 : $urandom_range(1, 300);
        v[REG_ROW_SCALE]   = $urandom_range(0, SCALE_SPAN);
        v[REG_COL_SCALE]   = $urandom_range(0, SCALE_SPAN);
        if ($urandom_range(0, 3) == 0) v[REG_ROW_SCALE] = -v[REG_ROW_SCALE];
        if ($urandom_range(0, 3) == 0) v[REG_COL_SCALE] = -v[REG_COL_SCALE];
        v[REG_ROW_OFFSET]  = $urandom_range(0, OFFSET_SPAN) - (OFFSET_SPAN / 2);
        v[REG_COL_OFFSET]  = $urandom_range(0, OFFSET_SPAN) - (OFFSET_SPAN / 2);
        case (ph)
            PH_HIGH: begin
                // largest scales and offsets: an origin saturates high where its peak index is not zero
                v[REG_MAP_WIDTH]   = 3;
                v[REG_IMAGE_WIDTH] = 4096;
                v[REG_CROP_HEIGHT] = 4096;
                v[REG_CROP_WIDTH]  = 4096;
                v[REG_ROW_SCALE]   = 32'h7FFF_FFFF;
                v[REG_ROW_OFFSET]  = 32'h7FFF_FFFF;
                v[REG_COL_SCALE]   = 32'h7FFF_FFFF;
                v[REG_COL_OFFSET]  = 32'h7FFF_FFFF;
            end
            PH_LOW: begin
                // zero image and crop sizes, most negative coefficients
                v[REG_MAP_WIDTH]   = 1;
                v[REG_IMAGE_WIDTH] = 0;
                v[REG_CROP_HEIGHT] = 0;
                v[REG_CROP_WIDTH]  = 0;
                v[REG_ROW_SCALE]   = 32'h8000_0000;
                v[REG_ROW_OFFSET]  = 32'h8000_0000;
                v[REG_COL_SCALE]   = 32'h8000_0000;
                v[REG_COL_OFFSET]  = 32'h8000_0000;
            end
            PH_WIDE: begin
                // widest fields, zero scales and offsets so every peak maps to the same origin
                v[REG_MAP_WIDTH]   = 7;
                v[REG_IMAGE_WIDTH] = 8191;
                v[REG_CROP_HEIGHT] = 8191;
                v[REG_CROP_WIDTH]  = 8191;
                v[REG_ROW_SCALE]   = 0;
                v[REG_ROW_OFFSET]  = 0;
                v[REG_COL_SCALE]   = 0;
                v[REG_COL_OFFSET]  = 0;
            end
            PH_ROW_WRAP: v[REG_MAP_WIDTH] = 0;
            PH_COL_WRAP: v[REG_MAP_WIDTH] = 2047;
            default: ;
        endcase
        for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), v[i]);
        // an index past the register list must be dropped
        write_reg(REG_UNUSED_LO + CFG_IDX_W'($urandom_range(0, 7)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every expected window, then let the pipe settle
    task automatic drain();
        while (crop_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic check_field(string name, logic signed [63:0] want_v,
                               logic signed [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Stimulus and final verdict
    initial begin
        int items;
        int budget;
        int len;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i])
            send_score(DIRECTED[i].score, DIRECTED[i].last, DIRECTED[i].typed,
                       DIRECTED[i].want);
        s_tvalid <= 1'b0;
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            load_settings(ph);
            budget = 24;
            if (ph == PH_HIGH || ph == PH_LOW || ph == PH_WIDE) budget = 10;
            if (ph == PH_ROW_WRAP || ph == PH_COL_WRAP) begin
                budget = 0;
                send_channel(LONG_LEN, LONG_PEAK);
            end
            if (ph == PH_HOLD) begin
                budget   = 40;
                hold_req = 1'b1;
            end
            items = 0;
            while (items < budget) begin
                // short channels fill the result stages fast during the hold-off
                if (ph == PH_HOLD || $urandom_range(0, 3) == 0) len = $urandom_range(1, 4);
                else len = $urandom_range(5, 24);
                send_channel(len, -1);
                items += len;
            end
            s_tvalid <= 1'b0;
            drain();
        end

        repeat (END_CYCLES) @(posedge aclk);
        if (mismatches == 0 && crop_q.size() == 0) begin
            $display("heatmap_argmax_crop_window_unit test passed");
        end else begin
            $display("heatmap_argmax_crop_window_unit test failed");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off, field-by-field check
    initial begin
        int    stall;
        crop_t got;
        crop_t want;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = draw_wait(SIDE_SINK);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got.peak_row   = m_tdata[9:0];
            got.peak_col   = m_tdata[19:10];
            got.peak_score = m_tdata[35:20];
            got.origin_row = m_tdata[51:36];
            got.origin_col = m_tdata[67:52];
            got.top_pad    = m_tdata[83:68];
            got.left_pad   = m_tdata[99:84];
            got.source_col = m_tdata[114:100];
            got.copy_width = m_tdata[127:115];
            got.skip_patch = m_tdata[128];
            if (crop_q.size() == 0) begin
                $display("%0t: result with none expected, got %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = crop_q.pop_front();
                check_field("peak_row",   want.peak_row,   got.peak_row);
                check_field("peak_col",   want.peak_col,   got.peak_col);
                check_field("peak_score", want.peak_score, got.peak_score);
                check_field("origin_row", want.origin_row, got.origin_row);
                check_field("origin_col", want.origin_col, got.origin_col);
                check_field("top_pad",    want.top_pad,    got.top_pad);
                check_field("left_pad",   want.left_pad,   got.left_pad);
                check_field("source_col", want.source_col, got.source_col);
                check_field("copy_width", want.copy_width, got.copy_width);
                check_field("skip_patch", want.skip_patch, got.skip_patch);
            end
            @(negedge aclk);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("heatmap_argmax_crop_window_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- sim.f -----
hdl/hmac_pkg.sv
hdl/hmac_tracker.sv
hdl/hmac_axis.sv
hdl/hmac_clip.sv
hdl/heatmap_argmax_crop_window_unit.sv
sim/tb_heatmap_argmax_crop_window_unit.sv
